### rtl/range_row_gap_interpolator_assert.svh
// assertion macros for the row gap interpolator
`ifndef RANGE_ROW_GAP_INTERPOLATOR_ASSERT_SVH
`define RANGE_ROW_GAP_INTERPOLATOR_ASSERT_SVH

// condition implies property in the same cycle
`define RRGI_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition implies property in the next cycle
`define RRGI_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/rrgi_pkg.sv
// shared constants, types and helper functions of the row gap interpolator
package rrgi_pkg;

    localparam int MAX_SPAN  = 3;
    localparam int HOLD_N    = MAX_SPAN - 1;
    localparam int HC_W      = $clog2(MAX_SPAN);
    localparam int HIDX_W    = (HOLD_N > 1) ? $clog2(HOLD_N) : 1;
    localparam int SPAN_W    = $clog2(MAX_SPAN + 1);

    localparam int COORD_W   = 20;
    localparam int INT_W     = 8;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int DIFF_W    = 21;
    localparam int NUM_W     = 24;
    localparam int MUL_W     = 27;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int G_W       = REG_W + SPAN_W;
    localparam int D2_W      = 42;
    localparam int R2_W      = 40;
    localparam int A_W       = 40;
    localparam int HALF_W    = 20;
    localparam int SQ_W      = 32;
    localparam int RHS_W     = 80;
    localparam int LHS_SHIFT = 32;
    localparam int RECIP_SHIFT = 27;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ERROR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FACTOR = 2'd2;

    localparam logic [REG_W-1:0] MAX_ERROR_RST    = 16'd1000;
    localparam logic [REG_W-1:0] BASE_ERROR_RST   = 16'd300;
    localparam logic [REG_W-1:0] ANGLE_FACTOR_RST = 16'd500;

    localparam logic [INT_W-1:0] FILL_INTENSITY = 8'd1;
    localparam logic [INT_W-1:0] HELD_INTENSITY = 8'd0;

    // ceiling reciprocals, exact floor division for dividends below 2^24
    localparam logic [MUL_W-1:0] RECIP_2 = MUL_W'(((2 ** RECIP_SHIFT) + 1) / 2);
    localparam logic [MUL_W-1:0] RECIP_3 = MUL_W'(((2 ** RECIP_SHIFT) + 2) / 3);
    localparam logic [MUL_W-1:0] RECIP_4 = MUL_W'(((2 ** RECIP_SHIFT) + 3) / 4);
    localparam logic [MUL_W-1:0] RECIP_5 = MUL_W'(((2 ** RECIP_SHIFT) + 4) / 5);
    localparam logic [MUL_W-1:0] RECIP_6 = MUL_W'(((2 ** RECIP_SHIFT) + 5) / 6);
    localparam logic [MUL_W-1:0] RECIP_7 = MUL_W'(((2 ** RECIP_SHIFT) + 6) / 7);
    localparam logic [MUL_W-1:0] RECIP_8 = MUL_W'(((2 ** RECIP_SHIFT) + 7) / 8);

    typedef enum logic [4:0] {
        OP_NONE, OP_G, OP_DX, OP_GG, OP_DY, OP_DZ, OP_AX, OP_AY, OP_AZ,
        OP_CX, OP_CY, OP_CZ, OP_MM, OP_BB, OP_R2, OP_LL, OP_LH, OP_HL, OP_HH,
        OP_IX, OP_IY, OP_IZ
    } op_t;

    typedef enum logic [1:0] {
        SRC_CUR, SRC_HELD, SRC_FILL
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_GAP, ST_GAP_WB, ST_DECIDE, ST_EMIT,
        ST_I_ADD, ST_I_MX, ST_I_MY, ST_I_MZ, ST_I_WB, ST_I_OUT
    } state_t;

    typedef struct packed {
        logic              cap_in;
        op_t               op;
        logic [SPAN_W-1:0] span;
        logic              hold_we;
        logic [HIDX_W-1:0] hold_idx;
        logic              anchor_we;
        logic              num_clr;
        logic              num_step;
        logic              out_load;
        src_t              out_src;
        logic [HIDX_W-1:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic cur_missing;
        logic cur_row_end;
        logic gap_ok;
        logic out_free;
    } sts_t;

    // magnitude of a signed difference
    function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : v;
    endfunction

    // reciprocal for a gap span
    function automatic logic [MUL_W-1:0] recip(input logic [SPAN_W-1:0] s);
        logic [MUL_W-1:0] r;
        case (int'(s))
            2: r = RECIP_2;
            3: r = RECIP_3;
            4: r = RECIP_4;
            5: r = RECIP_5;
            6: r = RECIP_6;
            7: r = RECIP_7;
            8: r = RECIP_8;
            default: r = RECIP_2;
        endcase
        return r;
    endfunction

endpackage

### rtl/rrgi_ctrl.sv
// controller state machine: sequences gap test, fill and result transactions
module rrgi_ctrl
    import rrgi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [HC_W-1:0] hc_reg, hc_next;
    logic [HC_W-1:0] e_reg, e_next;
    logic            anchor_reg, anchor_next;
    logic            fill_reg, fill_next;
    logic            can_hold;

    assign can_hold = sts.cur_missing && anchor_reg && !sts.cur_row_end
                      && (hc_reg < HC_W'(HOLD_N));

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_NONE;
            hc_reg     <= '0;
            e_reg      <= '0;
            anchor_reg <= 1'b0;
            fill_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            hc_reg     <= hc_next;
            e_reg      <= e_next;
            anchor_reg <= anchor_next;
            fill_reg   <= fill_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        hc_next     = hc_reg;
        e_next      = e_reg;
        anchor_next = anchor_reg;
        fill_next   = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                e_next    = '0;
                fill_next = 1'b0;
                if (can_hold)
                begin
                    hc_next    = hc_reg + HC_W'(1);
                    state_next = ST_IDLE;
                end
                else if (!sts.cur_missing && anchor_reg && (hc_reg != '0))
                begin
                    op_next    = OP_G;
                    state_next = ST_GAP;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_GAP:
            begin
                if (op_reg == OP_HH)
                    state_next = ST_GAP_WB;
                else
                    op_next = op_t'(op_reg + 5'd1);
            end
            ST_GAP_WB: state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                fill_next  = sts.gap_ok;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (e_reg == hc_reg)
                begin
                    if (sts.out_free)
                    begin
                        hc_next     = '0;
                        anchor_next = !sts.cur_missing && !sts.cur_row_end;
                        state_next  = ST_IDLE;
                    end
                end
                else if (fill_reg)
                    state_next = ST_I_ADD;
                else if (sts.out_free)
                    e_next = e_reg + HC_W'(1);
            end
            ST_I_ADD: state_next = ST_I_MX;
            ST_I_MX:  state_next = ST_I_MY;
            ST_I_MY:  state_next = ST_I_MZ;
            ST_I_MZ:  state_next = ST_I_WB;
            ST_I_WB:  state_next = ST_I_OUT;
            ST_I_OUT:
            begin
                if (sts.out_free)
                begin
                    e_next     = e_reg + HC_W'(1);
                    state_next = ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.op        = OP_NONE;
        cmd.out_src   = SRC_CUR;
        cmd.span      = SPAN_W'(hc_reg) + SPAN_W'(1);
        cmd.hold_idx  = hc_reg[HIDX_W-1:0];
        cmd.out_idx   = e_reg[HIDX_W-1:0];
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.cap_in = in_valid;
            end
            ST_DISPATCH: cmd.hold_we = can_hold;
            ST_GAP:      cmd.op = op_reg;
            ST_DECIDE:   cmd.num_clr = 1'b1;
            ST_EMIT:
            begin
                if (e_reg == hc_reg)
                begin
                    cmd.out_load  = sts.out_free;
                    cmd.out_src   = SRC_CUR;
                    cmd.anchor_we = sts.out_free && !sts.cur_missing && !sts.cur_row_end;
                end
                else if (!fill_reg)
                begin
                    cmd.out_load = sts.out_free;
                    cmd.out_src  = SRC_HELD;
                end
            end
            ST_I_ADD: cmd.num_step = 1'b1;
            ST_I_MX:  cmd.op = OP_IX;
            ST_I_MY:  cmd.op = OP_IY;
            ST_I_MZ:  cmd.op = OP_IZ;
            ST_I_OUT:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_src  = SRC_FILL;
            end
            default: ;
        endcase
    end

endmodule

### rtl/rrgi_dp.sv
// datapath: point registers, shared multiplier, gap test and output register
module rrgi_dp
    import rrgi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [REG_W-1:0]          cfg_data,
    input  logic signed [COORD_W-1:0] x_mm,
    input  logic signed [COORD_W-1:0] y_mm,
    input  logic signed [COORD_W-1:0] z_mm,
    input  logic [INT_W-1:0]          intensity,
    input  logic                      row_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_x_mm,
    output logic signed [COORD_W-1:0] out_y_mm,
    output logic signed [COORD_W-1:0] out_z_mm,
    output logic [INT_W-1:0]          out_intensity,
    output logic                      was_filled,
    output logic                      out_row_end,
    output logic                      last_of_run,
    input  cmd_t                      cmd,
    output sts_t                      sts
);

    logic [REG_W-1:0] max_err_reg, base_err_reg, factor_reg;

    logic signed [COORD_W-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic [INT_W-1:0]          cur_int_reg;
    logic                      cur_rend_reg;
    logic signed [COORD_W-1:0] anc_x_reg, anc_y_reg, anc_z_reg;
    logic signed [COORD_W-1:0] held_x_reg [HOLD_N];
    logic signed [COORD_W-1:0] held_y_reg [HOLD_N];
    logic signed [COORD_W-1:0] held_z_reg [HOLD_N];

    logic signed [DIFF_W-1:0]  diff_x, diff_y, diff_z;
    logic signed [NUM_W-1:0]   num_x_reg, num_y_reg, num_z_reg;
    logic signed [COORD_W-1:0] fill_x_reg, fill_y_reg, fill_z_reg;

    logic [MUL_W-1:0]  opa, opb;
    logic [PROD_W-1:0] prod_reg;
    op_t               wb_reg;

    logic [G_W-1:0]    g_reg;
    logic [A_W-1:0]    a_reg;
    logic [D2_W-1:0]   d2_reg;
    logic [R2_W-1:0]   ra_reg, rb_reg, r2_reg;
    logic [SQ_W-1:0]   mm2_reg, bb2_reg;
    logic [RHS_W-1:0]  rhs_reg;
    logic [RHS_W-1:0]  lhs;

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [INT_W-1:0]          out_int_reg;
    logic                      out_fill_reg, out_rend_reg, out_last_reg;

    logic [NUM_W-1:0]          q;
    logic signed [NUM_W:0]     q_off;
    logic signed [NUM_W-1:0]   num_sel;
    logic signed [COORD_W-1:0] anc_sel;
    logic signed [COORD_W-1:0] fill_val;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_err_reg  <= MAX_ERROR_RST;
            base_err_reg <= BASE_ERROR_RST;
            factor_reg   <= ANGLE_FACTOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_ERROR:    max_err_reg  <= cfg_data;
                REG_BASE_ERROR:   base_err_reg <= cfg_data;
                REG_ANGLE_FACTOR: factor_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // current point, anchor and held points
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            cur_x_reg    <= x_mm;
            cur_y_reg    <= y_mm;
            cur_z_reg    <= z_mm;
            cur_int_reg  <= intensity;
            cur_rend_reg <= row_end;
        end
        if (cmd.anchor_we)
        begin
            anc_x_reg <= cur_x_reg;
            anc_y_reg <= cur_y_reg;
            anc_z_reg <= cur_z_reg;
        end
        if (cmd.hold_we)
        begin
            held_x_reg[cmd.hold_idx] <= cur_x_reg;
            held_y_reg[cmd.hold_idx] <= cur_y_reg;
            held_z_reg[cmd.hold_idx] <= cur_z_reg;
        end
    end

    assign diff_x = DIFF_W'(cur_x_reg) - DIFF_W'(anc_x_reg);
    assign diff_y = DIFF_W'(cur_y_reg) - DIFF_W'(anc_y_reg);
    assign diff_z = DIFF_W'(cur_z_reg) - DIFF_W'(anc_z_reg);

    // interpolation numerators, one difference added per filled point
    always_ff @(posedge clk)
    begin
        if (cmd.num_clr)
        begin
            num_x_reg <= '0;
            num_y_reg <= '0;
            num_z_reg <= '0;
        end
        else if (cmd.num_step)
        begin
            num_x_reg <= num_x_reg + NUM_W'(diff_x);
            num_y_reg <= num_y_reg + NUM_W'(diff_y);
            num_z_reg <= num_z_reg + NUM_W'(diff_z);
        end
    end

    // rounded magnitude to divide: |num| + span/2
    function automatic logic [MUL_W-1:0] round_in(input logic signed [NUM_W-1:0] n,
                                                  input logic [SPAN_W-1:0] s);
        logic [NUM_W-1:0] m;
        m = n[NUM_W-1] ? NUM_W'(-n) : n;
        return MUL_W'(m) + MUL_W'(s >> 1);
    endfunction

    // shared multiplier operand select
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (cmd.op)
            OP_G:  begin opa = MUL_W'(factor_reg); opb = MUL_W'(cmd.span); end
            OP_DX: begin opa = MUL_W'(mag_diff(diff_x)); opb = opa; end
            OP_DY: begin opa = MUL_W'(mag_diff(diff_y)); opb = opa; end
            OP_DZ: begin opa = MUL_W'(mag_diff(diff_z)); opb = opa; end
            OP_GG: begin opa = MUL_W'(g_reg); opb = opa; end
            OP_AX: begin opa = MUL_W'(mag_diff(DIFF_W'(anc_x_reg))); opb = opa; end
            OP_AY: begin opa = MUL_W'(mag_diff(DIFF_W'(anc_y_reg))); opb = opa; end
            OP_AZ: begin opa = MUL_W'(mag_diff(DIFF_W'(anc_z_reg))); opb = opa; end
            OP_CX: begin opa = MUL_W'(mag_diff(DIFF_W'(cur_x_reg))); opb = opa; end
            OP_CY: begin opa = MUL_W'(mag_diff(DIFF_W'(cur_y_reg))); opb = opa; end
            OP_CZ: begin opa = MUL_W'(mag_diff(DIFF_W'(cur_z_reg))); opb = opa; end
            OP_MM: begin opa = MUL_W'(max_err_reg); opb = opa; end
            OP_BB: begin opa = MUL_W'(base_err_reg); opb = opa; end
            OP_LL: begin opa = MUL_W'(a_reg[HALF_W-1:0]); opb = MUL_W'(r2_reg[HALF_W-1:0]); end
            OP_LH: begin opa = MUL_W'(a_reg[HALF_W-1:0]); opb = MUL_W'(r2_reg[R2_W-1:HALF_W]); end
            OP_HL: begin opa = MUL_W'(a_reg[A_W-1:HALF_W]); opb = MUL_W'(r2_reg[HALF_W-1:0]); end
            OP_HH: begin opa = MUL_W'(a_reg[A_W-1:HALF_W]); opb = MUL_W'(r2_reg[R2_W-1:HALF_W]); end
            OP_IX: begin opa = round_in(num_x_reg, cmd.span); opb = recip(cmd.span); end
            OP_IY: begin opa = round_in(num_y_reg, cmd.span); opb = recip(cmd.span); end
            OP_IZ: begin opa = round_in(num_z_reg, cmd.span); opb = recip(cmd.span); end
            default: ;
        endcase
    end

    // multiplier stage and write-back tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_reg <= OP_NONE;
        else
            wb_reg <= cmd.op;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
    end

    // quotient with sign, added to the anchor coordinate
    always_comb
    begin
        case (wb_reg)
            OP_IY:   begin num_sel = num_y_reg; anc_sel = anc_y_reg; end
            OP_IZ:   begin num_sel = num_z_reg; anc_sel = anc_z_reg; end
            default: begin num_sel = num_x_reg; anc_sel = anc_x_reg; end
        endcase
        q        = prod_reg[RECIP_SHIFT +: NUM_W];
        q_off    = num_sel[NUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        fill_val = COORD_W'((NUM_W + 1)'(anc_sel) + q_off);
    end

    // accumulate products
    always_ff @(posedge clk)
    begin
        case (wb_reg)
            OP_G:  g_reg   <= prod_reg[G_W-1:0];
            OP_DX: d2_reg  <= prod_reg[D2_W-1:0];
            OP_DY: d2_reg  <= d2_reg + prod_reg[D2_W-1:0];
            OP_DZ: d2_reg  <= d2_reg + prod_reg[D2_W-1:0];
            OP_GG: a_reg   <= prod_reg[A_W-1:0];
            OP_AX: ra_reg  <= prod_reg[R2_W-1:0];
            OP_AY: ra_reg  <= ra_reg + prod_reg[R2_W-1:0];
            OP_AZ: ra_reg  <= ra_reg + prod_reg[R2_W-1:0];
            OP_CX: rb_reg  <= prod_reg[R2_W-1:0];
            OP_CY: rb_reg  <= rb_reg + prod_reg[R2_W-1:0];
            OP_CZ: rb_reg  <= rb_reg + prod_reg[R2_W-1:0];
            OP_MM: mm2_reg <= prod_reg[SQ_W-1:0];
            OP_BB: bb2_reg <= prod_reg[SQ_W-1:0];
            OP_LL: rhs_reg <= RHS_W'(prod_reg);
            OP_LH: rhs_reg <= rhs_reg + (RHS_W'(prod_reg) << HALF_W);
            OP_HL: rhs_reg <= rhs_reg + (RHS_W'(prod_reg) << HALF_W);
            OP_HH: rhs_reg <= rhs_reg + (RHS_W'(prod_reg) << (2 * HALF_W));
            OP_IX: fill_x_reg <= fill_val;
            OP_IY: fill_y_reg <= fill_val;
            OP_IZ: fill_z_reg <= fill_val;
            default: ;
        endcase
        // larger norm of the two bounding points
        if (cmd.op == OP_R2)
            r2_reg <= (ra_reg > rb_reg) ? ra_reg : rb_reg;
    end

    // gap test on squared values
    assign lhs = RHS_W'(d2_reg) << LHS_SHIFT;

    assign sts.gap_ok = (d2_reg < D2_W'(mm2_reg))
                        && ((d2_reg < D2_W'(bb2_reg)) || (lhs < rhs_reg));
    assign sts.cur_missing = (cur_int_reg == '0);
    assign sts.cur_row_end = cur_rend_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_src)
                SRC_HELD:
                begin
                    // held points are always missing points
                    out_x_reg    <= held_x_reg[cmd.out_idx];
                    out_y_reg    <= held_y_reg[cmd.out_idx];
                    out_z_reg    <= held_z_reg[cmd.out_idx];
                    out_int_reg  <= HELD_INTENSITY;
                    out_fill_reg <= 1'b0;
                    out_rend_reg <= 1'b0;
                    out_last_reg <= 1'b0;
                end
                SRC_FILL:
                begin
                    out_x_reg    <= fill_x_reg;
                    out_y_reg    <= fill_y_reg;
                    out_z_reg    <= fill_z_reg;
                    out_int_reg  <= FILL_INTENSITY;
                    out_fill_reg <= 1'b1;
                    out_rend_reg <= 1'b0;
                    out_last_reg <= 1'b0;
                end
                default:
                begin
                    out_x_reg    <= cur_x_reg;
                    out_y_reg    <= cur_y_reg;
                    out_z_reg    <= cur_z_reg;
                    out_int_reg  <= cur_int_reg;
                    out_fill_reg <= 1'b0;
                    out_rend_reg <= cur_rend_reg;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_x_mm      = out_x_reg;
    assign out_y_mm      = out_y_reg;
    assign out_z_mm      = out_z_reg;
    assign out_intensity = out_int_reg;
    assign was_filled    = out_fill_reg;
    assign out_row_end   = out_rend_reg;
    assign last_of_run   = out_last_reg;

endmodule

### rtl/range_row_gap_interpolator.sv
// top level of the row gap interpolator: controller, datapath and checks
// a point that closes no gap goes from dispatch through emit into the output register;
// a held missing point is stored in dispatch and the input is then ready again
// a point closing a gap of n held points: a gap test sequence on one shared 27x27
// multiplier, then a fill step sequence per filled point or a release, and then its own result
// output stalls hold each result; the input is ready again once all results are in the output
// register; reset: asynchronous active low, clears control state, thresholds 1000/300/500
`include "range_row_gap_interpolator_assert.svh"

module range_row_gap_interpolator
    import rrgi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [REG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] x_mm,
    input  logic signed [COORD_W-1:0] y_mm,
    input  logic signed [COORD_W-1:0] z_mm,
    input  logic [INT_W-1:0]          intensity,
    input  logic                      row_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_x_mm,
    output logic signed [COORD_W-1:0] out_y_mm,
    output logic signed [COORD_W-1:0] out_z_mm,
    output logic [INT_W-1:0]          out_intensity,
    output logic                      was_filled,
    output logic                      out_row_end,
    output logic                      last_of_run
);

    cmd_t cmd;
    sts_t sts;

    // controller
    rrgi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    rrgi_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .x_mm          (x_mm),
        .y_mm          (y_mm),
        .z_mm          (z_mm),
        .intensity     (intensity),
        .row_end       (row_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_x_mm      (out_x_mm),
        .out_y_mm      (out_y_mm),
        .out_z_mm      (out_z_mm),
        .out_intensity (out_intensity),
        .was_filled    (was_filled),
        .out_row_end   (out_row_end),
        .last_of_run   (last_of_run),
        .cmd           (cmd),
        .sts           (sts)
    );

    // checks
    `RRGI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held after accept")
    `RRGI_ASSERT_IMP(a_fill_marked, out_valid && was_filled, (out_intensity == FILL_INTENSITY) && !last_of_run && !out_row_end, "filled point wrongly marked")
    `RRGI_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "output register overwritten")

endmodule
